FILE: design/mf3_pkg.sv
// shared types, constants and compare helpers of the 3x3 median filter
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int NB_COUNT   = 9;
    localparam int WIN_COUNT  = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // queue between front and back, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
    } mf3_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_run;
        logic             frame_end;
    } mf3_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             interior;
        logic             border;
        logic             frame_last;
    } mf3_info_t;

    typedef struct packed {
        mf3_info_t                          info;
        logic [NB_COUNT-1:0][PIX_W-1:0]     nb;
    } mf3_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] hi;
    } mf3_sort3_t;

    function automatic mf3_sort3_t sort3(input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b,
                                         input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        mf3_sort3_t       r;
        x = (a < b) ? a : b;
        y = (a < b) ? b : a;
        if (c < x)
        begin
            r.lo = c;
            r.md = x;
            r.hi = y;
        end
        else if (c < y)
        begin
            r.lo = x;
            r.md = c;
            r.hi = y;
        end
        else
        begin
            r.lo = x;
            r.md = y;
            r.hi = c;
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    // median of three: larger of min(a,b) and min(max(a,b), c)
    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] z;
        x = (a < b) ? a : b;
        y = (a < b) ? b : a;
        z = (y < c) ? y : c;
        return (x > z) ? x : z;
    endfunction

endpackage

FILE: design/mf3_front.sv
// front end: frame counters, red line buffers, 3x3 window and pixel classification
module mf3_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  mf3_pkg::mf3_in_t                  pix,
    input  logic                              cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::SIZE_W-1:0]        cfg_data,
    input  logic [mf3_pkg::FIFO_CNT_W-1:0]    fifo_count,
    output logic                              push,
    output mf3_pkg::mf3_item_t                push_item
);

    logic [mf3_pkg::SIZE_W-1:0] width_reg;
    logic [mf3_pkg::SIZE_W-1:0] height_reg;
    logic [mf3_pkg::SIZE_W-1:0] w_eff;
    logic [mf3_pkg::SIZE_W-1:0] h_eff;
    logic [mf3_pkg::ROW_W-1:0]  row_reg;
    logic [mf3_pkg::ROW_W-1:0]  row_next;
    logic [mf3_pkg::COL_W-1:0]  col_reg;
    logic [mf3_pkg::COL_W-1:0]  col_next;
    logic [mf3_pkg::SIZE_W-1:0] row_inc;
    logic [mf3_pkg::SIZE_W-1:0] col_inc;
    logic                       accept;

    logic                       s1_valid_reg;
    mf3_pkg::mf3_info_t         s1_info_reg;
    mf3_pkg::mf3_info_t         s0_info;

    logic [mf3_pkg::PIX_W-1:0]  line_two_mem [mf3_pkg::MAX_WIDTH];
    logic [mf3_pkg::PIX_W-1:0]  line_one_mem [mf3_pkg::MAX_WIDTH];
    logic [mf3_pkg::PIX_W-1:0]  two_rd_reg;
    logic [mf3_pkg::PIX_W-1:0]  one_rd_reg;
    logic                       byp_reg;
    logic [mf3_pkg::PIX_W-1:0]  byp_top_reg;
    logic [mf3_pkg::PIX_W-1:0]  byp_mid_reg;
    logic [mf3_pkg::PIX_W-1:0]  top;
    logic [mf3_pkg::PIX_W-1:0]  mid;

    logic [mf3_pkg::PIX_W-1:0]  win_reg [mf3_pkg::WIN_COUNT];

    // out-of-range sizes clamp to 1 .. max
    always_comb
    begin
        if (width_reg == '0)
            w_eff = mf3_pkg::SIZE_W'(1);
        else if (width_reg > mf3_pkg::SIZE_W'(mf3_pkg::MAX_WIDTH))
            w_eff = mf3_pkg::SIZE_W'(mf3_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = mf3_pkg::SIZE_W'(1);
        else if (height_reg > mf3_pkg::SIZE_W'(mf3_pkg::MAX_HEIGHT))
            h_eff = mf3_pkg::SIZE_W'(mf3_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // keep room in the queue for the transaction still in stage 1
    assign pix_ready = ({1'b0, fifo_count} + (mf3_pkg::FIFO_CNT_W + 1)'(s1_valid_reg))
                       < (mf3_pkg::FIFO_CNT_W + 1)'(mf3_pkg::FIFO_DEPTH);
    assign accept    = pix_valid && pix_ready;

    assign row_inc = mf3_pkg::SIZE_W'(row_reg) + mf3_pkg::SIZE_W'(1);
    assign col_inc = mf3_pkg::SIZE_W'(col_reg) + mf3_pkg::SIZE_W'(1);

    always_comb
    begin
        s0_info.red        = pix.in_red;
        s0_info.green      = pix.in_green;
        s0_info.blue       = pix.in_blue;
        s0_info.row        = row_reg;
        s0_info.col        = col_reg;
        s0_info.interior   = (row_reg >= mf3_pkg::ROW_W'(2)) && (col_reg >= mf3_pkg::COL_W'(2));
        s0_info.border     = (row_reg == '0) || (col_reg == '0) ||
                             (row_inc == h_eff) || (col_inc == w_eff);
        s0_info.frame_last = (row_inc == h_eff) && (col_inc == w_eff);
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[mf3_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[mf3_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mf3_pkg::WIDTH_RESET;
            height_reg   <= mf3_pkg::HEIGHT_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            byp_reg      <= s1_valid_reg && (s1_info_reg.col == col_reg);
            if (cfg_we)
            begin
                case (cfg_index)
                    mf3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    mf3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_info_reg <= s0_info;
        byp_top_reg <= mid;
        byp_mid_reg <= s1_info_reg.red;
    end

    // same-cycle write and read of a column: one-pixel rows or a cfg_we restart
    assign top = byp_reg ? byp_top_reg : two_rd_reg;
    assign mid = byp_reg ? byp_mid_reg : one_rd_reg;

    always_ff @(posedge clk)
    begin
        two_rd_reg <= line_two_mem[col_reg];
        one_rd_reg <= line_one_mem[col_reg];
        if (s1_valid_reg)
        begin
            line_two_mem[s1_info_reg.col] <= mid;
            line_one_mem[s1_info_reg.col] <= s1_info_reg.red;
        end
    end

    // window: entries 0..2 column c-2, 3..5 column c-1, top to bottom
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mf3_pkg::WIN_COUNT; i++)
                win_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < mf3_pkg::WIN_COUNT; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_info_reg.red;
        end
    end

    // pixels with no result never enter the queue
    assign push = s1_valid_reg && (s1_info_reg.interior || s1_info_reg.border);

    always_comb
    begin
        push_item.info  = s1_info_reg;
        push_item.nb[0] = win_reg[0];
        push_item.nb[1] = win_reg[3];
        push_item.nb[2] = top;
        push_item.nb[3] = win_reg[1];
        push_item.nb[4] = win_reg[4];
        push_item.nb[5] = mid;
        push_item.nb[6] = win_reg[2];
        push_item.nb[7] = win_reg[5];
        push_item.nb[8] = s1_info_reg.red;
    end

endmodule

FILE: design/mf3_fifo.sv
// short queue of classified pixels between front and back
module mf3_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  mf3_pkg::mf3_item_t              push_item,
    input  logic                            pop,
    output logic                            pop_valid,
    output mf3_pkg::mf3_item_t              pop_item,
    output logic [mf3_pkg::FIFO_CNT_W-1:0]  count
);

    mf3_pkg::mf3_item_t                   store_reg [mf3_pkg::FIFO_DEPTH];
    logic [mf3_pkg::FIFO_PTR_W-1:0]       wr_ptr_reg;
    logic [mf3_pkg::FIFO_PTR_W-1:0]       rd_ptr_reg;
    logic [mf3_pkg::FIFO_CNT_W-1:0]       count_reg;
    logic                                 do_pop;

    assign pop_valid = count_reg != '0;
    assign pop_item  = store_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + mf3_pkg::FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + mf3_pkg::FIFO_PTR_W'(1);
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + mf3_pkg::FIFO_CNT_W'(1);
                2'b01:   count_reg <= count_reg - mf3_pkg::FIFO_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < mf3_pkg::FIFO_CNT_W'(mf3_pkg::FIFO_DEPTH)) || do_pop)
        else $error("queue push while full");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> count_reg == $past(count_reg) + mf3_pkg::FIFO_CNT_W'(1))
        else $error("queue count did not follow a push");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

FILE: design/mf3_back.sv
// back end: pipelined median-of-nine network and result sequencing
module mf3_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  mf3_pkg::mf3_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output mf3_pkg::mf3_out_t    res
);

    // stage a: each row sorted
    logic                       a_valid_reg;
    mf3_pkg::mf3_info_t         a_info_reg;
    mf3_pkg::mf3_sort3_t        a_sort_reg [3];
    // stage b: max of lows, median of middles, min of highs
    logic                       b_valid_reg;
    mf3_pkg::mf3_info_t         b_info_reg;
    logic [mf3_pkg::PIX_W-1:0]  b_lo_reg;
    logic [mf3_pkg::PIX_W-1:0]  b_md_reg;
    logic [mf3_pkg::PIX_W-1:0]  b_hi_reg;
    // stage c: output register, one or two results per transaction
    logic                       c_valid_reg;
    mf3_pkg::mf3_info_t         c_info_reg;
    logic [mf3_pkg::PIX_W-1:0]  c_med_reg;
    logic                       c_phase_reg;

    logic                       two_results;
    logic                       c_done;
    logic                       c_free;
    logic                       b_free;
    logic                       a_free;

    assign two_results = c_info_reg.interior && c_info_reg.border;
    assign c_done      = c_valid_reg && res_ready && (c_phase_reg || !two_results);
    assign c_free      = !c_valid_reg || c_done;
    assign b_free      = !b_valid_reg || c_free;
    assign a_free      = !a_valid_reg || b_free;
    assign item_pop    = item_valid && a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_phase_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= item_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
                c_phase_reg <= 1'b0;
            end
            else if (res_ready && !c_phase_reg && two_results)
            begin
                c_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            a_info_reg    <= item.info;
            a_sort_reg[0] <= mf3_pkg::sort3(item.nb[0], item.nb[1], item.nb[2]);
            a_sort_reg[1] <= mf3_pkg::sort3(item.nb[3], item.nb[4], item.nb[5]);
            a_sort_reg[2] <= mf3_pkg::sort3(item.nb[6], item.nb[7], item.nb[8]);
        end
        if (b_free && a_valid_reg)
        begin
            b_info_reg <= a_info_reg;
            b_lo_reg   <= mf3_pkg::max3(a_sort_reg[0].lo, a_sort_reg[1].lo,
                                        a_sort_reg[2].lo);
            b_md_reg   <= mf3_pkg::med3(a_sort_reg[0].md, a_sort_reg[1].md,
                                        a_sort_reg[2].md);
            b_hi_reg   <= mf3_pkg::min3(a_sort_reg[0].hi, a_sort_reg[1].hi,
                                        a_sort_reg[2].hi);
        end
        if (c_free && b_valid_reg)
        begin
            c_info_reg <= b_info_reg;
            c_med_reg  <= mf3_pkg::med3(b_lo_reg, b_md_reg, b_hi_reg);
        end
    end

    // median of the pixel up and left first, then the arriving border pixel
    always_comb
    begin
        res_valid = c_valid_reg;
        if (!c_phase_reg && c_info_reg.interior)
        begin
            res.out_red     = c_med_reg;
            res.out_green   = c_med_reg;
            res.out_blue    = c_med_reg;
            res.out_row     = c_info_reg.row - mf3_pkg::ROW_W'(1);
            res.out_col     = c_info_reg.col - mf3_pkg::COL_W'(1);
            res.last_of_run = !c_info_reg.border;
            res.frame_end   = 1'b0;
        end
        else
        begin
            res.out_red     = c_info_reg.red;
            res.out_green   = c_info_reg.green;
            res.out_blue    = c_info_reg.blue;
            res.out_row     = c_info_reg.row;
            res.out_col     = c_info_reg.col;
            res.last_of_run = 1'b1;
            res.frame_end   = c_info_reg.frame_last;
        end
    end

`ifndef SYNTH
    a_phase_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        c_phase_reg |-> c_valid_reg && c_info_reg.interior && c_info_reg.border)
        else $error("second result phase on a single-result transaction");
    a_pair_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && res_ready && !c_phase_reg && two_results) |=>
        (c_valid_reg && c_phase_reg))
        else $error("border result of a pair was dropped");
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_end) |-> res.last_of_run)
        else $error("frame end on a result that is not last of its run");
`endif

endmodule

FILE: design/median_filter_3x3_pixels.sv
// 3x3 red median filter over a raster pixel stream: one pixel accepted per clock while the
// queue between front and back has room; each pixel yields zero, one or two results,
// delivered one per clock while res_ready is high, through an output register, so the
// output side limits the average rate (two results for a pixel on the last row or column
// with at least two rows above and two columns to its left); a pixel passes stage 1, the
// queue and back-end stages a, b and c before its first result, and the line buffers
// (1024 entries each) have no clearing pass after reset
module median_filter_3x3_pixels (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  mf3_pkg::mf3_in_t                 pix,
    output logic                             res_valid,
    input  logic                             res_ready,
    output mf3_pkg::mf3_out_t                res,
    input  logic                             cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::SIZE_W-1:0]       cfg_data
);

    logic                             push;
    mf3_pkg::mf3_item_t               push_item;
    logic                             pop;
    logic                             pop_valid;
    mf3_pkg::mf3_item_t               pop_item;
    logic [mf3_pkg::FIFO_CNT_W-1:0]   fifo_count;

    mf3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_count (fifo_count),
        .push       (push),
        .push_item  (push_item)
    );

    mf3_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .count     (fifo_count)
    );

    mf3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_pop   (pop),
        .item       (pop_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
